@@ rtl/core/lpe_pkg.sv @@
// Shared types and constants for the Legendre polynomial evaluator.
// Used by lpe_cell and legendre_polynomial_eval; depends on nothing.

package lpe_pkg;

  // Fixed field widths
  localparam int DEGREE_W    = 5;    // degree field on the input item
  localparam int Q16_W       = 18;   // Q1.16 abscissa and result
  localparam int Q30_W       = 32;   // Q2.30 internal terms
  localparam int DEG_W       = 8;    // clamped degree carried down the chain
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam int MAX_DEGREE_DEF = 31;

  // Fixed-point constants
  localparam logic signed [Q16_W-1:0] Q16_ONE  = 18'sd65536;
  localparam logic signed [Q16_W-1:0] Q16_MONE = -18'sd65536;
  localparam logic signed [Q30_W-1:0] Q30_ONE  = 32'sh4000_0000;

  // Data handed from one recurrence cell to the next
  typedef struct packed {
    logic [DEG_W-1:0]        deg;   // clamped degree of this item
    logic signed [Q30_W-1:0] x30;   // abscissa in Q2.30
    logic signed [Q30_W-1:0] cur;   // P_{i-1}
    logic signed [Q30_W-1:0] prev;  // P_{i-2}
  } lpe_link_t;

endpackage

@@ rtl/core/lpe_cell.sv @@
// One recurrence cell: computes P_STEP from P_{STEP-1} and P_{STEP-2} in an
// eight-stage pipeline. Depends on lpe_pkg for the link type and widths.

module lpe_cell import lpe_pkg::*; #(
  parameter int STEP = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      link_vld_i,
  input  lpe_link_t link_i,
  output logic      link_vld_o,
  output lpe_link_t link_o
);

  localparam int NSTG  = 8;
  // |num| < 3*STEP*2^31 < 2^(33+clog2(STEP))
  localparam int MAG_W = 33 + $clog2(STEP);
  localparam int NUM_W = MAG_W + 1;
  localparam int LO_W  = (MAG_W + 1) / 2;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int PW    = 2 * MAG_W;

  // floor(2^MAG_W / STEP): quotient estimate is low by at most one
  localparam logic [63:0]      RECIP64 = (64'd1 << MAG_W) / 64'(STEP);
  localparam logic [MAG_W-1:0] RECIP   = RECIP64[MAG_W-1:0];

  localparam logic signed [NUM_W-1:0] C_ODD  = NUM_W'(2 * STEP - 1);
  localparam logic signed [NUM_W-1:0] C_PREV = NUM_W'(STEP - 1);
  localparam logic [MAG_W-1:0]        C_STEP = MAG_W'(STEP);
  localparam logic [MAG_W-1:0]        POS_LIM = MAG_W'(64'h7FFF_FFFF);
  localparam logic [MAG_W-1:0]        NEG_LIM = MAG_W'(64'h8000_0000);
  localparam logic signed [63:0]      TRUNC_BIAS = 64'sd1073741823;
  localparam logic [DEG_W-1:0]        STEP_DEG = DEG_W'(STEP);

  logic [NSTG-1:0] vld_r;
  lpe_link_t       pay_r [NSTG];

  logic signed [63:0]       p_r;
  logic signed [32:0]       prodq_r;
  logic signed [NUM_W-1:0]  num_r;
  logic                     neg_r, neg4_r, neg5_r, neg6_r;
  logic [MAG_W-1:0]         mag_r, mag4_r, mag5_r;
  logic [2*HI_W-1:0]        pp_hh_r;
  logic [HI_W+LO_W-1:0]     pp_hl_r, pp_lh_r;
  logic [2*LO_W-1:0]        pp_ll_r;
  logic [MAG_W-1:0]         q0_r, q_r;

  logic signed [63:0]       p_adj;
  logic [PW-1:0]            pp_sum;
  logic [MAG_W-1:0]         rem;
  logic signed [Q30_W-1:0]  sat_val;
  lpe_link_t                step_nxt;

  // Truncate the Q4.60 product toward zero back to Q2.30
  assign p_adj = p_r + (p_r[63] ? TRUNC_BIAS : 64'sd0);

  // Reassemble the reciprocal product from its four partial products
  assign pp_sum = (PW'(pp_hh_r) << (2 * LO_W)) + (PW'(pp_hl_r) << LO_W)
                + (PW'(pp_lh_r) << LO_W) + PW'(pp_ll_r);

  // Remainder left by the quotient estimate
  assign rem = mag5_r - q0_r * C_STEP;

  // Apply sign and saturate to the Q2.30 range
  always_comb begin
    if (neg6_r) begin
      sat_val = (q_r > NEG_LIM) ? 32'sh8000_0000 : -$signed(q_r[Q30_W-1:0]);
    end else begin
      sat_val = (q_r > POS_LIM) ? 32'sh7FFF_FFFF : $signed(q_r[Q30_W-1:0]);
    end
  end

  // Shift the recurrence, or pass through past the item's degree
  always_comb begin
    step_nxt = pay_r[6];
    if (pay_r[6].deg >= STEP_DEG) begin
      step_nxt.cur  = sat_val;
      step_nxt.prev = pay_r[6].cur;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], link_vld_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // s0: x * P_{i-1}
      pay_r[0] <= link_i;
      p_r      <= 64'(link_i.x30) * 64'(link_i.cur);
      // s1: back to Q2.30
      pay_r[1] <= pay_r[0];
      prodq_r  <= 33'(p_adj >>> 30);
      // s2: numerator
      pay_r[2] <= pay_r[1];
      num_r    <= NUM_W'(prodq_r) * C_ODD - NUM_W'(pay_r[1].prev) * C_PREV;
      // s3: sign and magnitude
      pay_r[3] <= pay_r[2];
      neg_r    <= num_r[NUM_W-1];
      mag_r    <= num_r[NUM_W-1] ? MAG_W'(-num_r) : MAG_W'(num_r);
      // s4: partial products of magnitude times reciprocal
      pay_r[4] <= pay_r[3];
      pp_hh_r  <= (2 * HI_W)'(mag_r[MAG_W-1:LO_W]) * (2 * HI_W)'(RECIP[MAG_W-1:LO_W]);
      pp_hl_r  <= (HI_W + LO_W)'(mag_r[MAG_W-1:LO_W]) * (HI_W + LO_W)'(RECIP[LO_W-1:0]);
      pp_lh_r  <= (HI_W + LO_W)'(mag_r[LO_W-1:0]) * (HI_W + LO_W)'(RECIP[MAG_W-1:LO_W]);
      pp_ll_r  <= (2 * LO_W)'(mag_r[LO_W-1:0]) * (2 * LO_W)'(RECIP[LO_W-1:0]);
      mag4_r   <= mag_r;
      neg4_r   <= neg_r;
      // s5: quotient estimate
      pay_r[5] <= pay_r[4];
      q0_r     <= pp_sum[PW-1:MAG_W];
      mag5_r   <= mag4_r;
      neg5_r   <= neg4_r;
      // s6: one correction step
      pay_r[6] <= pay_r[5];
      q_r      <= (rem >= C_STEP) ? q0_r + MAG_W'(1) : q0_r;
      neg6_r   <= neg5_r;
      // s7: recurrence result
      pay_r[7] <= step_nxt;
    end
  end

  assign link_vld_o = vld_r[NSTG-1];
  assign link_o     = pay_r[NSTG-1];

  // Reciprocal estimate never misses by more than one
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (rem < (C_STEP << 1)))
    else $error("lpe_cell: quotient estimate off by more than one");

  // Numerator stays inside its magnitude bound
  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (mag_r <= (MAG_W'(3 * STEP) << 31)))
    else $error("lpe_cell: numerator magnitude out of range");

  // Items past their degree leave the cell with P unchanged
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[NSTG-2] && (pay_r[NSTG-2].deg < STEP_DEG))
      |=> (link_o.cur == $past(pay_r[NSTG-2].cur)))
    else $error("lpe_cell: pass-through item altered");

endmodule

@@ rtl/core/legendre_polynomial_eval.sv @@
// Top level of the Legendre polynomial evaluator: input clamp, chain of
// lpe_cell recurrence cells, rounding stage and output register.
// Depends on lpe_pkg and lpe_cell.
//
//   Channel | Ports                          | Item contents
//   --------+--------------------------------+------------------------------
//   input   | in_tvalid/in_tready/in_tdata   | degree, abscissa (Q1.16)
//   result  | out_tvalid/out_tready/out_tdata| value = P_degree(x) (Q1.16)
//
// For every degree, each item walks the entry stage, all cells, the rounding
// stage and the output register in turn; every cell spends eight stages on
// one step (32x32 product, numerator, split reciprocal multiply for the
// divide by i, correction).
// A new item can enter every cycle unless the chain holds; the chain is one pipeline.
// Reset clears valid bits only. The whole chain holds while a finished result
// waits in the output register and another one sits in the rounding stage.

module legendre_polynomial_eval import lpe_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [4:0] degree, [22:5] abscissa
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [17:0] value
);

  localparam logic [32:0] ROUND_HALF = 33'd8192;

  logic                      adv;
  logic                      c_vld [1:MAX_DEGREE];
  lpe_link_t                 c_lnk [1:MAX_DEGREE];

  logic                      ent_vld_r;
  lpe_link_t                 ent_lnk_r;

  logic [DEGREE_W-1:0]       in_deg;
  logic signed [Q16_W-1:0]   in_x;
  logic signed [Q16_W-1:0]   x_clamp;
  logic [DEG_W-1:0]          deg_clamp;

  logic                      f1_vld_r;
  logic                      f1_zero_r, f1_one_r, f1_neg_r;
  logic [Q30_W-1:0]          f1_mag_r;
  logic signed [Q16_W-1:0]   f1_x16_r;

  logic                      out_vld_r;
  logic signed [Q16_W-1:0]   out_val_r;

  logic [Q16_W:0]            rnd;
  logic [Q16_W:0]            rnd_c;
  logic signed [Q16_W-1:0]   val_nxt;

  // Chain advances unless a result is held and another is ready behind it
  assign adv       = !(out_vld_r && !out_tready && f1_vld_r);
  assign in_tready = adv;

  // Input field unpack and clamp
  assign in_deg = in_tdata[DEGREE_W-1:0];
  assign in_x   = $signed(in_tdata[DEGREE_W+Q16_W-1:DEGREE_W]);

  always_comb begin
    if (in_x > Q16_ONE) begin
      x_clamp = Q16_ONE;
    end else if (in_x < Q16_MONE) begin
      x_clamp = Q16_MONE;
    end else begin
      x_clamp = in_x;
    end
    if (32'(in_deg) > MAX_DEGREE) begin
      deg_clamp = DEG_W'(MAX_DEGREE);
    end else begin
      deg_clamp = DEG_W'(in_deg);
    end
  end

  // Entry stage: P0 = 1, P1 = x
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (adv) begin
      ent_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_lnk_r.deg  <= deg_clamp;
      ent_lnk_r.x30  <= 32'(x_clamp) <<< 14;
      ent_lnk_r.cur  <= 32'(x_clamp) <<< 14;
      ent_lnk_r.prev <= Q30_ONE;
    end
  end

  assign c_vld[1] = ent_vld_r;
  assign c_lnk[1] = ent_lnk_r;

  // Recurrence cells, step 2 up to MAX_DEGREE
  for (genvar g = 2; g <= MAX_DEGREE; g++) begin : g_cell
    lpe_cell #(
      .STEP (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (adv),
      .link_vld_i (c_vld[g-1]),
      .link_i     (c_lnk[g-1]),
      .link_vld_o (c_vld[g]),
      .link_o     (c_lnk[g])
    );
  end

  // Rounding stage: special degrees and magnitude of the final term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= c_vld[MAX_DEGREE];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_zero_r <= (c_lnk[MAX_DEGREE].deg == DEG_W'(0));
      f1_one_r  <= (c_lnk[MAX_DEGREE].deg == DEG_W'(1));
      f1_neg_r  <= c_lnk[MAX_DEGREE].cur[Q30_W-1];
      f1_mag_r  <= c_lnk[MAX_DEGREE].cur[Q30_W-1] ? Q30_W'(-c_lnk[MAX_DEGREE].cur)
                                                  : Q30_W'(c_lnk[MAX_DEGREE].cur);
      f1_x16_r  <= Q16_W'(c_lnk[MAX_DEGREE].x30 >>> 14);
    end
  end

  // Round half away from zero on 14 bits, saturate to [-1, 1]
  always_comb begin
    rnd   = (Q16_W + 1)'((33'(f1_mag_r) + ROUND_HALF) >> 14);
    rnd_c = (rnd > (Q16_W + 1)'(Q16_ONE)) ? (Q16_W + 1)'(Q16_ONE) : rnd;
    if (f1_zero_r) begin
      val_nxt = Q16_ONE;
    end else if (f1_one_r) begin
      val_nxt = f1_x16_r;
    end else if (f1_neg_r) begin
      val_nxt = -$signed(rnd_c[Q16_W-1:0]);
    end else begin
      val_nxt = $signed(rnd_c[Q16_W-1:0]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && f1_vld_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && f1_vld_r) begin
      out_val_r <= val_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-Q16_W){1'b0}}, out_val_r};

  // Result always within [-1, 1]
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_val_r <= Q16_ONE && out_val_r >= Q16_MONE))
    else $error("legendre_polynomial_eval: result out of range");

  // Degree zero gives exactly one
  a_deg0: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && f1_vld_r && f1_zero_r) |=> (out_vld_r && out_val_r == Q16_ONE))
    else $error("legendre_polynomial_eval: degree zero not one");

  // Degree one gives the clamped abscissa
  a_deg1: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && f1_vld_r && f1_one_r && !f1_zero_r) |=> (out_val_r == $past(f1_x16_r)))
    else $error("legendre_polynomial_eval: degree one not x");

  // A held result freezes the item behind it
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (f1_vld_r && out_vld_r && !out_tready) |=> (f1_vld_r && $stable(f1_mag_r)))
    else $error("legendre_polynomial_eval: rounding stage lost its item");

endmodule

@@ test/legendre_polynomial_eval_test.sv @@
// Self-checking testbench for legendre_polynomial_eval: drives degree/abscissa items,
// predicts P_n(x) with a fixed-point recurrence of its own and compares each result.
// Depends on lpe_pkg and the legendre_polynomial_eval RTL.

module legendre_polynomial_eval_test;
  import lpe_pkg::*;

  localparam int     LATENCY     = 8 * (MAX_DEGREE_DEF - 1) + 3;
  localparam int     CYCLE_LIMIT = 200000;
  localparam longint Q30_UNIT    = 64'sd1073741824;
  localparam longint Q30_HI      = 64'sd2147483647;
  localparam longint Q30_LO      = -64'sd2147483648;
  localparam longint Q16_UNIT    = 64'sd65536;

  typedef struct {
    logic [DEGREE_W-1:0]     degree;
    logic [Q16_W-1:0]        abscissa;
    logic signed [Q16_W-1:0] value;
  } legendre_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [4:0] degree, [22:5] abscissa
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [17:0] value

  legendre_item_t pending_values[$];
  legendre_item_t head_item;
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             burst_left = 0;
  bit             no_gaps = 1'b0;
  logic [8:0]     ready_phase = '0;

  legendre_polynomial_eval DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // P_n(x) by the three-term recurrence in Q2.30, rounded to Q1.16
  function automatic logic signed [Q16_W-1:0] legendre_value(
    input logic [DEGREE_W-1:0] degree,
    input logic [Q16_W-1:0]    abscissa
  );
    longint x16, x30, p_prev, p_cur, prod, num, p_next, mag, rounded;
    int     n, i;
    x16 = longint'($signed(abscissa));
    if (x16 > Q16_UNIT) x16 = Q16_UNIT;
    if (x16 < -Q16_UNIT) x16 = -Q16_UNIT;
    n = int'(degree);
    if (n > MAX_DEGREE_DEF) n = MAX_DEGREE_DEF;
    x30 = x16 * 64'sd16384;
    p_prev = Q30_UNIT;
    p_cur = x30;
    if (n == 0) return Q16_ONE;
    if (n == 1) return x16[Q16_W-1:0];
    for (i = 2; i <= n; i++) begin
      prod = (x30 * p_cur) / Q30_UNIT;
      num = longint'(2 * i - 1) * prod - longint'(i - 1) * p_prev;
      p_next = num / longint'(i);
      if (p_next > Q30_HI) p_next = Q30_HI;
      if (p_next < Q30_LO) p_next = Q30_LO;
      p_prev = p_cur;
      p_cur = p_next;
    end
    // round half away from zero on the 14 dropped bits, then clamp to [-1,1]
    mag = (p_cur < 0) ? -p_cur : p_cur;
    rounded = (mag + 64'sd8192) / 64'sd16384;
    if (p_cur < 0) rounded = -rounded;
    if (rounded > Q16_UNIT) rounded = Q16_UNIT;
    if (rounded < -Q16_UNIT) rounded = -Q16_UNIT;
    return rounded[Q16_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Present one item, honoring the burst/gap pattern, and log its expected value
  task automatic send_item(input logic [DEGREE_W-1:0] degree, input logic [Q16_W-1:0] abscissa);
    int             gap;
    legendre_item_t item;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - DEGREE_W - Q16_W){1'b0}}, abscissa, degree};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    item.degree   = degree;
    item.abscissa = abscissa;
    item.value    = legendre_value(degree, abscissa);
    pending_values = {pending_values, item};
  endtask

  function automatic logic [Q16_W-1:0] rand_abscissa();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: begin
        // any 18-bit pattern, about half of them out of range
        return Q16_W'($urandom_range(18'h3FFFF));
      end
      1: begin
        // close to the ends of [-1,1]
        return Q16_W'(($urandom_range(1) ? 18'sd65536 : -18'sd65536)
                      + $urandom_range(64) - 32);
      end
      2: begin
        return Q16_W'($urandom_range(256) - 128);
      end
      default: begin
        return Q16_W'($urandom_range(131072) - 65536);
      end
    endcase
  endfunction

  function automatic logic [DEGREE_W-1:0] rand_degree();
    int sel;
    sel = $urandom_range(3);
    case (sel)
      0: return DEGREE_W'($urandom_range(3));
      1: return DEGREE_W'($urandom_range(MAX_DEGREE_DEF - 3, MAX_DEGREE_DEF));
      default: return DEGREE_W'($urandom_range(MAX_DEGREE_DEF));
    endcase
  endfunction

  // Result check plus receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", $signed(out_tdata[Q16_W-1:0])));
      end else begin
        head_item = pending_values.pop_front();
        if (out_tdata[Q16_W-1:0] !== head_item.value) begin
          report_mismatch($sformatf("deg %0d x %0d: value %0d, want %0d",
                                    head_item.degree, $signed(head_item.abscissa),
                                    $signed(out_tdata[Q16_W-1:0]), head_item.value));
        end
      end
    end
    ready_phase <= ready_phase + 1'b1;
    case (ready_phase[8:7])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= $urandom_range(1);
      2'd2: out_tready <= ($urandom_range(7) == 0);
      default: out_tready <= (ready_phase[3:0] < 4'd11);
    endcase
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_degree_zero();
    send_item(5'd0, 18'sd0);
    send_item(5'd0, 18'sd65536);
    send_item(5'd0, -18'sd65536);
    send_item(5'd0, 18'h1FFFF);
  endtask

  // degree one passes x through, clamped when out of range
  task automatic test_degree_one();
    send_item(5'd1, -18'sd65536);
    send_item(5'd1, 18'sd65536);
    send_item(5'd1, 18'sd0);
    send_item(5'd1, 18'sd12345);
    send_item(5'd1, 18'h1FFFF);
    send_item(5'd1, 18'h20000);
    send_item(5'd1, 18'sd65537);
  endtask

  task automatic test_top_degree();
    send_item(5'd31, 18'sd65536);
    send_item(5'd31, -18'sd65536);
    send_item(5'd31, 18'sd0);
    send_item(5'd31, 18'sd1);
    send_item(5'd31, -18'sd1);
    send_item(5'd31, 18'sd46341);
    send_item(5'd31, 18'h20000);
  endtask

  task automatic test_mid_degrees();
    send_item(5'd2, 18'sd32768);
    send_item(5'd2, 18'sd37837);
    send_item(5'd3, -18'sd50000);
    send_item(5'd15, 18'sd65535);
    send_item(5'd16, -18'sd65535);
  endtask

  task automatic test_back_to_back();
    int k;
    no_gaps = 1'b1;
    for (k = 0; k < 60; k++) send_item(rand_degree(), rand_abscissa());
    no_gaps = 1'b0;
  endtask

  task automatic test_random();
    int k;
    for (k = 0; k < 490; k++) send_item(rand_degree(), rand_abscissa());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_degree_zero();
    test_degree_one();
    test_top_degree();
    test_mid_degrees();
    test_back_to_back();
    test_random();
    in_tvalid <= 1'b0;
    // drain, then watch for stray results
    while (pending_values.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
